[hw/rtl/grwc_pkg.sv]
// Shared constants, the Q1.14 sine table and angle helpers of the grid ray caster.
// Depends on nothing; the caster top level imports it.
`timescale 1ns / 1ps

package grwc_pkg;

  // Grid and screen geometry.
  localparam int MAP_SIDE      = 8;
  localparam int MAP_BITS      = 3;
  localparam int MAP_CELLS     = MAP_SIDE * MAP_SIDE;
  localparam int CELL_SIZE     = 64;
  localparam int CELL_BITS     = 12;
  localparam int CELL_Q6       = CELL_SIZE * 64;
  localparam int GRID_Q6       = MAP_SIDE * CELL_Q6;
  localparam int MAX_STEPS     = 8;
  localparam int SCREEN_HEIGHT = 640;
  localparam int HALF_HEIGHT   = SCREEN_HEIGHT / 2;

  // Arithmetic constants.
  localparam int NOHIT_DIST = 6400000;
  localparam int AXIS_LIMIT = 16;
  localparam int HEIGHT_NUM = CELL_SIZE * SCREEN_HEIGHT * 64;
  localparam int STEP_NUM   = 32 << 16;
  localparam int ONE_Q14    = 16384;
  localparam int HALF_TURN  = 360;
  localparam int FULL_TURN  = 720;
  localparam int QUARTER    = 180;

  // Serial divider geometry.
  localparam int DIV_W  = 31;
  localparam int DVS_W  = 23;

  typedef logic [14:0] sin_tab_t [0:QUARTER];

  // Quarter-wave sine by an eight-term series in Q30, rounded to Q1.14.
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    longint v;
    for (int k = 0; k <= QUARTER; k++) begin
      x    = longint'(k) * 64'd3373259426 / 64'd360;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = (term * x2) >> 30;
        case (n)
          1:       term = term / 64'd6;
          2:       term = term / 64'd20;
          3:       term = term / 64'd42;
          4:       term = term / 64'd72;
          5:       term = term / 64'd110;
          6:       term = term / 64'd156;
          default: term = term / 64'd210;
        endcase
        if (n % 2 == 1) sum = sum - longint'(term);
        else            sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (sum + 32768) >>> 16;
      if (v > ONE_Q14) v = ONE_Q14;
      t[k] = v[14:0];
    end
    return t;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  // Fold an angle below two full turns into one turn.
  function automatic logic [9:0] wrap_hd(logic [10:0] k);
    logic [10:0] r;
    r = (k >= 11'(FULL_TURN)) ? k - 11'(FULL_TURN) : k;
    return r[9:0];
  endfunction

  // Signed Q1.14 sine of an angle in half degrees, angle below one turn.
  function automatic logic signed [15:0] sin_hd(logic [9:0] k);
    logic [9:0]  idx;
    logic        neg;
    logic [14:0] mag;
    if (k <= 10'(QUARTER)) begin
      idx = k;                   neg = 1'b0;
    end else if (k <= 10'(HALF_TURN)) begin
      idx = 10'(HALF_TURN) - k;  neg = 1'b0;
    end else if (k <= 10'(HALF_TURN + QUARTER)) begin
      idx = k - 10'(HALF_TURN);  neg = 1'b1;
    end else begin
      idx = 10'(FULL_TURN) - k;  neg = 1'b1;
    end
    mag = SIN_TAB[idx[7:0]];
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

[hw/rtl/grid_ray_wall_caster.sv]
// Grid ray caster top level: map store, wall walks, projection and column setup.
// Depends on grwc_pkg for geometry constants, the sine table and angle helpers.
`timescale 1ns / 1ps

// Usage:
//   The slave channel takes one item per handshake. tuser = 0 writes one map
//   cell (cell_index, cell_value) and gives no result.
//   tuser = 1 casts one ray and gives exactly one result item on the master
//   channel.
//   A cast walks the vertical grid crossings, then the horizontal ones, up to
//   eight cells each, through one shared 30x30 multiplier and one radix-2
//   serial divider. A cast makes up to four divisions, and each cell step
//   passes the states S_WMUL, S_WCELL and S_WCHK. The block takes no new item
//   while a cast is in work.
//   The result sits in an output register; the next item is accepted while it
//   waits. A cast that finishes while the receiver still stalls holds until
//   the register is free.
//   Reset empties the map (per-cell valid bits clear at once) and drops any
//   pending result; no clearing pass is needed. No item is taken during reset.
module grid_ray_wall_caster (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cell_index[5:0], cell_value[8:6], player_x[23:9], player_y[38:24],
  // player_angle[48:39], ray_angle[58:49], zero fill up to bit 63
  input  logic [63:0] s_tdata,
  // req_type[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // hit_found[0], wall_distance[23:1], line_height[33:24], line_offset[42:34],
  // texture_id[45:43], texture_column[50:46], vertical_side[51],
  // texture_row_start[72:52], texture_row_step[94:73], zero fill bit 95
  output logic [95:0] m_tdata
);
  import grwc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_TRIG, S_WSET, S_DIV, S_WQ, S_WMUL, S_WCELL, S_WCHK,
    S_PMUL1, S_PMUL2, S_PSUB, S_FISH, S_FCLAMP, S_RAW, S_STEP, S_FIN
  } state_t;

  state_t state;
  state_t div_ret;

  // Cast context.
  logic        dir;
  logic [14:0] px, py;
  logic [9:0]  pa, ra;
  logic signed [15:0] s, c, cf;
  logic signed [17:0] m;
  logic        step_neg;
  logic [2:0]  nstep;
  logic signed [28:0] q;
  logic        q_neg;
  logic signed [28:0] other;
  logic        in_grid;
  logic [2:0]  cell_hit;
  logic signed [59:0] prod, acc;
  logic        fin_rdy;
  logic        fin_fire;

  // Walk results.
  logic        v_hit, h_hit;
  logic [22:0] v_dist, h_dist;
  logic [4:0]  v_tc, h_tc;
  logic [2:0]  v_cell, h_cell;

  // Column setup.
  logic [22:0] dist_c;
  logic [21:0] raw, rstep;

  // Serial divider.
  logic [DVS_W-1:0] div_rem, div_dvs;
  logic [DIV_W-1:0] div_quo;
  logic [4:0]       div_cnt;

  // Map memory and its valid bits.
  logic [2:0] map_mem [0:MAP_CELLS-1];
  logic [MAP_CELLS-1:0] map_vld;
  logic [2:0] rd_data;
  logic       rd_vld;
  logic [2*MAP_BITS-1:0] rd_addr;

  // Combinational helpers.
  logic signed [17:0] px_s, py_s, pm, po, floor_pm;
  logic signed [15:0] axis_den, q_num, q_den;
  logic [14:0] q_num_mag, q_den_mag;
  logic signed [29:0] mul_a, mul_b;
  logic signed [59:0] t16, t14p, t14f;
  logic signed [28:0] other_n, cx, cy, hx, hy;
  logic        cgrid;
  logic [DVS_W:0] div_sh;
  logic        div_ge;
  logic [DVS_W:0] div_diff;
  logic [2:0]  cell_now;
  logic        vwin;
  logic        best_hit;
  logic [22:0] best_dist;
  logic [4:0]  best_tc;
  logic [2:0]  best_cell;
  logic [9:0]  height;
  logic [4:0]  tcol;
  logic [20:0] row_start;
  logic signed [59:0] pdiff;

  wire accept = s_tvalid && s_tready;
  assign s_tready = !rst && (state == S_IDLE);

  // The result leaves the last state once its product is ready and the register is free.
  assign fin_fire = (state == S_FIN) && fin_rdy && !(m_tvalid && !m_tready);

  // Operand selection and walk geometry.
  always_comb begin
    px_s      = $signed({3'b0, px});
    py_s      = $signed({3'b0, py});
    pm        = dir ? py_s : px_s;
    po        = dir ? px_s : py_s;
    floor_pm  = $signed({pm[17:CELL_BITS], {CELL_BITS{1'b0}}});
    axis_den  = dir ? -s : c;
    q_num     = dir ? c : s;
    q_den     = dir ? s : c;
    q_num_mag = q_num[15] ? 15'(-q_num) : q_num[14:0];
    q_den_mag = q_den[15] ? 15'(-q_den) : q_den[14:0];

    t16     = prod[59] ? (prod + 60'sd65535) >>> 16 : prod >>> 16;
    other_n = 29'(po) + t16[28:0];
    cx      = dir ? other_n : 29'(m);
    cy      = dir ? 29'(m) : other_n;
    cgrid   = (cx >= 0) && (cx < 29'(GRID_Q6)) && (cy >= 0) && (cy < 29'(GRID_Q6));
    rd_addr = {cy[CELL_BITS +: MAP_BITS], cx[CELL_BITS +: MAP_BITS]};
    hx      = dir ? other : 29'(m);
    hy      = dir ? 29'(m) : other;

    pdiff = acc - prod;
    t14p  = pdiff[59] ? (pdiff + 60'sd16383) >>> 14 : pdiff >>> 14;
    t14f  = prod[59] ? (prod + 60'sd16383) >>> 14 : prod >>> 14;

    div_sh   = {div_rem, div_quo[DIV_W-1]};
    div_ge   = div_sh >= {1'b0, div_dvs};
    div_diff = div_sh - {1'b0, div_dvs};

    cell_now = (in_grid && rd_vld) ? rd_data : 3'd0;

    vwin      = v_dist < h_dist;
    best_hit  = vwin ? v_hit : h_hit;
    best_dist = vwin ? v_dist : h_dist;
    best_tc   = vwin ? v_tc : h_tc;
    best_cell = vwin ? v_cell : h_cell;

    height    = (raw > 22'(SCREEN_HEIGHT)) ? 10'(SCREEN_HEIGHT) : raw[9:0];
    row_start = (raw > 22'(SCREEN_HEIGHT)) ? prod[21:1] : 21'd0;
    if (!best_hit) tcol = 5'd0;
    else if (vwin) tcol = (ra > 10'(QUARTER) && ra < 10'(HALF_TURN + QUARTER)) ?
                          5'd31 - best_tc : best_tc;
    else           tcol = (ra > 10'(HALF_TURN)) ? 5'd31 - best_tc : best_tc;

    mul_a = '0;
    mul_b = '0;
    case (state)
      S_WMUL:  begin mul_a = 30'(pm) - 30'(m);   mul_b = 30'(q); end
      S_PMUL1: begin mul_a = 30'(c);             mul_b = 30'(hx) - 30'(px_s); end
      S_PMUL2: begin mul_a = 30'(s);             mul_b = 30'(hy) - 30'(py_s); end
      S_FISH:  begin mul_a = $signed({7'b0, best_dist}); mul_b = 30'(cf); end
      S_FIN:   begin
        mul_a = $signed({8'b0, raw}) - 30'sd640;
        mul_b = $signed({8'b0, rstep});
      end
      default: ;
    endcase
  end

  // Map storage: written by write items, read one cell per walk step.
  always_ff @(posedge clk) begin
    if (accept && !s_tuser) map_mem[s_tdata[5:0]] <= s_tdata[8:6];
    rd_data <= map_mem[rd_addr];
  end

  // Shared multiplier, registered.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Sequencer with its context and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      map_vld  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !fin_fire) m_tvalid <= 1'b0;
      rd_vld <= map_vld[rd_addr];
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!s_tuser) begin
              map_vld[s_tdata[5:0]] <= 1'b1;
            end else begin
              px    <= s_tdata[23:9];
              py    <= s_tdata[38:24];
              pa    <= wrap_hd({1'b0, s_tdata[48:39]});
              ra    <= wrap_hd({1'b0, s_tdata[58:49]});
              state <= S_TRIG;
            end
          end
        end
        S_TRIG: begin
          s     <= sin_hd(ra);
          c     <= sin_hd(wrap_hd(11'(ra) + 11'(QUARTER)));
          cf    <= sin_hd(wrap_hd(11'(wrap_hd(11'(pa) + 11'(FULL_TURN) - 11'(ra)))
                                  + 11'(QUARTER)));
          dir   <= 1'b0;
          state <= S_WSET;
        end
        S_WSET: begin
          nstep   <= '0;
          q_neg   <= q_num[15] ^ q_den[15];
          div_quo <= {q_num_mag, 16'b0};
          div_rem <= '0;
          div_dvs <= 23'(q_den_mag);
          div_cnt <= '0;
          div_ret <= S_WQ;
          if (axis_den > 16'sd16) begin
            m        <= floor_pm + 18'sd4096;
            step_neg <= 1'b0;
            state    <= S_DIV;
          end else if (axis_den < -16'sd16) begin
            m        <= floor_pm - 18'sd1;
            step_neg <= 1'b1;
            state    <= S_DIV;
          end else begin
            // Ray along the axis: this walk finds nothing.
            if (!dir) begin
              v_hit <= 1'b0; v_dist <= 23'(NOHIT_DIST); v_tc <= '0; v_cell <= '0;
              dir   <= 1'b1;
              state <= S_WSET;
            end else begin
              h_hit <= 1'b0; h_dist <= 23'(NOHIT_DIST); h_tc <= '0; h_cell <= '0;
              state <= S_FISH;
            end
          end
        end
        S_DIV: begin
          div_rem <= div_ge ? div_diff[DVS_W-1:0] : div_sh[DVS_W-1:0];
          div_quo <= {div_quo[DIV_W-2:0], div_ge};
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'(DIV_W - 1)) state <= div_ret;
        end
        S_WQ: begin
          q     <= q_neg ? -$signed({2'b0, div_quo[26:0]}) : $signed({2'b0, div_quo[26:0]});
          state <= S_WMUL;
        end
        S_WMUL: begin
          state <= S_WCELL;
        end
        S_WCELL: begin
          other   <= other_n;
          in_grid <= cgrid;
          state   <= S_WCHK;
        end
        S_WCHK: begin
          if (cell_now != 3'd0) begin
            cell_hit <= cell_now;
            state    <= S_PMUL1;
          end else if (nstep == 3'(MAX_STEPS - 1)) begin
            if (!dir) begin
              v_hit <= 1'b0; v_dist <= 23'(NOHIT_DIST); v_tc <= '0; v_cell <= '0;
              dir   <= 1'b1;
              state <= S_WSET;
            end else begin
              h_hit <= 1'b0; h_dist <= 23'(NOHIT_DIST); h_tc <= '0; h_cell <= '0;
              state <= S_FISH;
            end
          end else begin
            nstep <= nstep + 3'd1;
            m     <= step_neg ? m - 18'sd4096 : m + 18'sd4096;
            state <= S_WMUL;
          end
        end
        S_PMUL1: begin
          state <= S_PMUL2;
        end
        S_PMUL2: begin
          acc   <= prod;
          state <= S_PSUB;
        end
        S_PSUB: begin
          // Distance along the ray, clamped at zero; the hit point is in the grid.
          if (!dir) begin
            v_hit  <= 1'b1;
            v_dist <= t14p[59] ? 23'd0 : t14p[22:0];
            v_tc   <= other[11:7];
            v_cell <= cell_hit;
            dir    <= 1'b1;
            state  <= S_WSET;
          end else begin
            h_hit  <= 1'b1;
            h_dist <= t14p[59] ? 23'd0 : t14p[22:0];
            h_tc   <= other[11:7];
            h_cell <= cell_hit;
            state  <= S_FISH;
          end
        end
        S_FISH: begin
          state <= S_FCLAMP;
        end
        S_FCLAMP: begin
          // Fisheye correction with clamp, then raw height division.
          if (t14f < 0) begin
            dist_c  <= 23'd0;
            div_dvs <= 23'd1;
          end else if (t14f > 60'sd6400000) begin
            dist_c  <= 23'(NOHIT_DIST);
            div_dvs <= 23'(NOHIT_DIST);
          end else begin
            dist_c  <= t14f[22:0];
            div_dvs <= (t14f[22:0] == 23'd0) ? 23'd1 : t14f[22:0];
          end
          div_quo <= 31'(HEIGHT_NUM);
          div_rem <= '0;
          div_cnt <= '0;
          div_ret <= S_RAW;
          state   <= S_DIV;
        end
        S_RAW: begin
          raw <= div_quo[21:0];
          if (div_quo == '0) begin
            rstep <= 22'(STEP_NUM);
            state <= S_STEP;
          end else begin
            div_quo <= 31'(STEP_NUM);
            div_rem <= '0;
            div_dvs <= {1'b0, div_quo[21:0]};
            div_cnt <= '0;
            div_ret <= S_STEP;
            state   <= S_DIV;
          end
        end
        S_STEP: begin
          if (raw != '0) rstep <= div_quo[21:0];
          fin_rdy <= 1'b0;
          state   <= S_FIN;
        end
        S_FIN: begin
          // Product of the row start is ready in the cycle after entry.
          fin_rdy <= 1'b1;
          if (fin_fire) begin
            m_tvalid        <= 1'b1;
            m_tdata[0]      <= best_hit;
            m_tdata[23:1]   <= dist_c;
            m_tdata[33:24]  <= height;
            m_tdata[42:34]  <= 9'(HALF_HEIGHT) - 9'(height >> 1);
            m_tdata[45:43]  <= best_hit ? best_cell - 3'd1 : 3'd0;
            m_tdata[50:46]  <= tcol;
            m_tdata[51]     <= best_hit && vwin;
            m_tdata[72:52]  <= row_start;
            m_tdata[94:73]  <= rstep;
            m_tdata[95]     <= 1'b0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A cast item closes the input until its result is formed.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |=> !s_tready)
    else $error("input open right after a cast item");

  // Corrected distance never exceeds the no-hit value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:1] <= 23'(NOHIT_DIST)))
    else $error("wall distance out of range");

  // Column height is limited to the screen.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[33:24] <= 10'(SCREEN_HEIGHT)))
    else $error("line height out of range");

  // A miss carries no texture or side information.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |->
      (m_tdata[45:43] == 3'd0 && m_tdata[50:46] == 5'd0 && !m_tdata[51]))
    else $error("miss with texture fields set");

endmodule

[tb/tb_grid_ray_wall_caster.sv]
// Self-checking bench for the grid ray caster: map writes and ray casts go in on the slave
// stream, and each result is checked against a cycle-free SystemVerilog model of the caster.
// Depends on grwc_pkg and grid_ray_wall_caster.
`timescale 1ns / 1ps

module tb_grid_ray_wall_caster;
  import grwc_pkg::*;

  localparam int RUN_LIMIT = 1000000;
  localparam int CELL_W    = 4096;
  localparam int NO_HIT    = 6400000;
  localparam int AXIS_TOL  = 16;
  localparam int LONG_HOLD = 3000;

  typedef enum logic {REQ_WRITE = 1'b0, REQ_CAST = 1'b1} req_e;

  typedef struct {
    req_e        kind;
    logic [5:0]  idx;
    logic [2:0]  val;
    logic [14:0] px;
    logic [14:0] py;
    logic [9:0]  pang;
    logic [9:0]  rang;
    bit          drain;
  } ray_req_t;

  typedef struct packed {
    logic        pad;
    logic [21:0] row_step;
    logic [20:0] row_start;
    logic        vside;
    logic [4:0]  tcol;
    logic [2:0]  tid;
    logic [8:0]  offset;
    logic [9:0]  height;
    logic [22:0] wall_dist;
    logic        hit;
  } column_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;

  ray_req_t req_q[$];
  column_t  column_q[$];
  longint   sin_q14[0:180];
  logic [2:0] grid[0:63];
  int  cycles = 0;
  int  results = 0;
  int  errors = 0;
  bit  took = 1'b0;
  bit  held_long = 1'b0;

  grid_ray_wall_caster dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  // Quarter-wave sine in Q1.14 from an eight-term series in Q30.
  function automatic void build_sine();
    longint unsigned x, x2, term;
    longint sum, v;
    for (int k = 0; k <= 180; k++) begin
      x    = longint'(k) * 64'd3373259426 / 64'd360;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (sum + 32768) / 65536;
      if (v > 16384) v = 16384;
      sin_q14[k] = v;
    end
  endfunction

  function automatic longint sine_hd(int k);
    k = k % 720;
    if (k <= 180) return sin_q14[k];
    if (k <= 360) return sin_q14[360 - k];
    if (k <= 540) return -sin_q14[k - 360];
    return -sin_q14[720 - k];
  endfunction

  function automatic longint cosine_hd(int k);
    return sine_hd((k % 720) + 180);
  endfunction

  function automatic int wall_at(longint x, longint y);
    if (x < 0 || y < 0) return 0;
    if (x / CELL_W >= 8 || y / CELL_W >= 8) return 0;
    return grid[(y / CELL_W) * 8 + x / CELL_W];
  endfunction

  // Step across grid lines of one orientation and report the first wall met.
  function automatic void walk_lines(input longint px, py, s, c, input bit vert,
                                     output bit hit, output longint span, ex, ey,
                                     output int wall);
    longint pos, stride, slope, x, y, d;
    hit = 0; span = NO_HIT; ex = px; ey = py; wall = 0;
    if (vert) begin
      if (c > AXIS_TOL) begin pos = (px / CELL_W) * CELL_W + CELL_W; stride = CELL_W; end
      else if (c < -AXIS_TOL) begin pos = (px / CELL_W) * CELL_W - 1; stride = -CELL_W; end
      else return;
      slope = (s * 65536) / c;
    end else begin
      if (s > AXIS_TOL) begin pos = (py / CELL_W) * CELL_W - 1; stride = -CELL_W; end
      else if (s < -AXIS_TOL) begin pos = (py / CELL_W) * CELL_W + CELL_W; stride = CELL_W; end
      else return;
      slope = (c * 65536) / s;
    end
    for (int n = 0; n < 8; n++) begin
      if (vert) begin x = pos; y = py + ((px - pos) * slope) / 65536; end
      else begin y = pos; x = px + ((py - pos) * slope) / 65536; end
      ex = x; ey = y;
      wall = wall_at(x, y);
      if (wall != 0) begin
        hit = 1;
        d = (c * (x - px) - s * (y - py)) / 16384;
        span = d < 0 ? 0 : d;
        return;
      end
      pos += stride;
    end
  endfunction

  // Expected wall column for one cast against the current map.
  function automatic column_t cast_column(ray_req_t r);
    column_t o;
    longint s, c, dv, dh, exv, eyv, exh, eyh, span, raw, stp, start, height, ex, ey;
    bit hv, hh, vside, hit;
    int wv, wh, wall, pa, ra, tc;
    pa = r.pang % 720;
    ra = r.rang % 720;
    s = sine_hd(ra);
    c = cosine_hd(ra);
    walk_lines(r.px, r.py, s, c, 1'b1, hv, dv, exv, eyv, wv);
    walk_lines(r.px, r.py, s, c, 1'b0, hh, dh, exh, eyh, wh);
    vside = dv < dh;
    hit  = vside ? hv : hh;
    wall = vside ? wv : wh;
    ex   = vside ? exv : exh;
    ey   = vside ? eyv : eyh;
    span = ((vside ? dv : dh) * cosine_hd(pa + 720 - ra)) / 16384;
    if (span < 0) span = 0;
    if (span > NO_HIT) span = NO_HIT;
    o = '0;
    if (hit) begin
      o.tid = 3'(wall - 1);
      if (vside) begin
        tc = int'(((ey * 32) / CELL_W) & 31);
        if (ra > 180 && ra < 540) tc = 31 - tc;
      end else begin
        tc = int'(((ex * 32) / CELL_W) & 31);
        if (ra > 360) tc = 31 - tc;
      end
      o.tcol = 5'(tc);
      o.vside = vside;
    end
    raw = longint'(64 * 640 * 64) / (span < 1 ? 1 : span);
    stp = raw == 0 ? (longint'(32) << 16) : ((longint'(32) << 16) / raw);
    start = 0;
    height = raw;
    if (raw > 640) begin
      start = ((raw - 640) * stp) / 2;
      height = 640;
    end
    o.hit = hit;
    o.wall_dist = 23'(span);
    o.height = 10'(height);
    o.offset = 9'(320 - height / 2);
    o.row_start = 21'(start);
    o.row_step = 22'(stp);
    return o;
  endfunction

  function automatic void add_write(int idx, int val);
    ray_req_t r;
    r = '{kind: REQ_WRITE, idx: 6'(idx), val: 3'(val), px: 15'(0), py: 15'(0),
          pang: 10'(0), rang: 10'(0), drain: 1'b0};
    req_q.push_back(r);
  endfunction

  function automatic void add_cast(int px, int py, int pa, int ra);
    ray_req_t r;
    r = '{kind: REQ_CAST, idx: 6'($urandom), val: 3'($urandom), px: 15'(px), py: 15'(py),
          pang: 10'(pa), rang: 10'(ra), drain: 1'b0};
    req_q.push_back(r);
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Accepted items are predicted in order; results are checked in order.
  always @(posedge clk) begin
    column_t got, want;
    took = 1'b0;
    if (!rst) begin
      cycles++;
      if (s_tvalid && s_tready) begin
        took = 1'b1;
        if (s_tuser == REQ_WRITE) grid[s_tdata[5:0]] = s_tdata[8:6];
        else column_q.push_back(cast_column(req_q[0]));
        void'(req_q.pop_front());
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        results++;
        if (column_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, m_tdata);
          errors++;
        end else begin
          want = column_q.pop_front();
          check_field("hit_found", want.hit, got.hit);
          check_field("wall_distance", want.wall_dist, got.wall_dist);
          check_field("line_height", want.height, got.height);
          check_field("line_offset", want.offset, got.offset);
          check_field("texture_id", want.tid, got.tid);
          check_field("texture_column", want.tcol, got.tcol);
          check_field("vertical_side", want.vside, got.vside);
          check_field("texture_row_start", want.row_start, got.row_start);
          check_field("texture_row_step", want.row_step, got.row_step);
          check_field("zero fill", 0, got.pad);
        end
      end
      if (cycles > RUN_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Sender: bursts of random length with random gaps; a drain mark waits for all results.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    bit offer;
    offer = s_tvalid && !took;
    if (!rst && !offer && req_q.size() > 0) begin
      if (gap_left > 0) gap_left--;
      else if (!req_q[0].drain || (column_q.size() == 0 && !m_tvalid)) begin
        req_q[0].drain = 1'b0;
        offer = 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 20);
          gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 25);
        end
      end
    end
    if (offer && req_q.size() > 0) begin
      s_tuser <= req_q[0].kind;
      s_tdata <= {5'b0, req_q[0].rang, req_q[0].pang, req_q[0].py, req_q[0].px,
                  req_q[0].val, req_q[0].idx};
    end
    s_tvalid <= offer && req_q.size() > 0;
  end

  // Receiver: its own stall pattern, plus one long hold-off that backs the block up.
  int hold_left = 0;
  int mode_left = 0;
  int stall_pct = 0;
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else begin
      if (!held_long && results == 150) begin
        held_long = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(50, 600);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 30;
          2: stall_pct = 70;
          default: stall_pct = 95;
        endcase
      end else mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else m_tready <= $urandom_range(0, 99) >= stall_pct;
    end
  end

  // Stimulus: a directed opening, then rounds of map edits and casts.
  initial begin
    int px, py, pa;
    build_sine();
    foreach (grid[i]) grid[i] = '0;
    // Empty map: every ray misses; axis rays, wrapped angles and grid corners.
    add_cast(0, 0, 0, 0);
    add_cast(32767, 32767, 719, 1023);
    add_cast(16000, 16000, 180, 180);
    // Walls along rows 0 and 7 with every wall kind; then corner 0 is cleared, corner 63 rewritten and cell 8 set.
    for (int i = 0; i < 8; i++) begin
      add_write(i, 1 + i % 7);
      add_write(56 + i, 7);
    end
    add_write(0, 0);
    add_write(63, 7);
    add_write(8, 3);
    // Axis directions, diagonals, a ray behind the viewer, and wrapped angles from a corner.
    add_cast(16000, 16000, 0, 0);
    add_cast(16000, 16000, 360, 360);
    add_cast(16000, 16000, 540, 540);
    add_cast(16000, 16000, 90, 90);
    add_cast(10000, 20000, 270, 630);
    add_cast(10000, 20000, 0, 360);
    add_cast(100, 100, 720, 900);
    add_cast(20480, 20480, 450, 450);
    for (int round = 0; round < 40; round++) begin
      // Rewrite a few cells; mostly walls so casts find something.
      for (int w = 0; w < $urandom_range(3, 10); w++)
        add_write($urandom_range(0, 63), $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 7));
      if (round == 20) req_q[$].drain = 1'b1;
      for (int k = 0; k < 25; k++) begin
        px = $urandom_range(0, 32767);
        py = $urandom_range(0, 32767);
        pa = $urandom_range(0, 719);
        if ($urandom_range(0, 9) == 0)
          add_cast(px, py, $urandom_range(0, 1023), $urandom_range(0, 1023));
        else
          add_cast(px, py, pa, (pa + 720 + $urandom_range(0, 120) - 60) % 720);
      end
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (req_q.size() != 0 || column_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && column_q.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
